@@ hdl/dnle_pkg.sv @@
package dnle_pkg;

  localparam int MaxLabel = 62;
  localparam int CountW   = 6;
  localparam logic [7:0] DotChar = 8'd46;

  typedef struct packed {
    logic accept;
    logic load_len;
    logic load_ch;
    logic load_term;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic is_dot;
    logic ovf;
    logic count_zero;
    logic count_full;
    logic last_ch;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/dnle_ctrl.sv @@
module dnle_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            name_end,
  output logic            in_ready,
  input  dnle_pkg::stat_t stat,
  output dnle_pkg::cmd_t  cmd
);
  import dnle_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLen  = 3'd1;
  localparam logic [2:0] StCh   = 3'd2;
  localparam logic [2:0] StTerm = 3'd3;
  localparam logic [2:0] StErr  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pend_end;
  logic       pend_end_next;
  logic       ovf_now;

  assign in_ready = (state == StIdle);
  assign ovf_now  = stat.ovf | (~stat.is_dot & stat.count_full);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    pend_end_next = pend_end;
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (ovf_now) begin
            if (name_end) state_next = StErr;
          end else if (stat.is_dot) begin
            pend_end_next = name_end;
            if (!stat.count_zero) state_next = StLen;
            else if (name_end) state_next = StTerm;
          end else if (name_end) begin
            pend_end_next = 1'b1;
            state_next    = StLen;
          end
        end
      end
      StLen: begin
        if (stat.out_free) begin
          cmd.load_len = 1'b1;
          state_next   = StCh;
        end
      end
      StCh: begin
        if (stat.out_free) begin
          cmd.load_ch = 1'b1;
          if (stat.last_ch) state_next = pend_end ? StTerm : StIdle;
        end
      end
      StTerm: begin
        if (stat.out_free) begin
          cmd.load_term = 1'b1;
          state_next    = StIdle;
        end
      end
      StErr: begin
        if (stat.out_free) begin
          cmd.load_err = 1'b1;
          state_next   = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= StIdle;
      pend_end <= 1'b0;
    end else begin
      state    <= state_next;
      pend_end <= pend_end_next;
    end
  end

endmodule

@@ hdl/dnle_dp.sv @@
module dnle_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      ch,
  input  dnle_pkg::cmd_t  cmd,
  output dnle_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            bad_label
);
  import dnle_pkg::*;

  logic [7:0]        mem [MaxLabel];
  logic [CountW-1:0] count;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              ovf;
  logic              is_dot;
  logic              full;
  logic              last_ch;
  logic              load;

  assign is_dot  = (ch == DotChar);
  assign full    = (count == CountW'(MaxLabel));
  assign last_ch = (idx == count - CountW'(1));
  assign load    = cmd.load_len | cmd.load_ch | cmd.load_term | cmd.load_err;

  assign stat.is_dot     = is_dot;
  assign stat.ovf        = ovf;
  assign stat.count_zero = (count == '0);
  assign stat.count_full = full;
  assign stat.last_ch    = last_ch;
  assign stat.out_free   = ~out_valid | out_ready;

  always_comb begin
    if (cmd.load_len) rd_addr = '0;
    else if (cmd.load_ch && !last_ch) rd_addr = idx + CountW'(1);
    else rd_addr = idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !ovf && !is_dot && !full) mem[count] <= ch;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= rd_addr;
      if (cmd.accept && !ovf && !is_dot) begin
        if (full) begin
          ovf   <= 1'b1;
          count <= '0;
        end else begin
          count <= count + CountW'(1);
        end
      end
      if (cmd.load_ch && last_ch) count <= '0;
      if (cmd.load_err) begin
        ovf   <= 1'b0;
        count <= '0;
      end
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      out_byte  <= {{(8-CountW){1'b0}}, count};
      out_last  <= 1'b0;
      bad_label <= 1'b0;
    end else if (cmd.load_ch) begin
      out_byte  <= rd_data;
      out_last  <= 1'b0;
      bad_label <= 1'b0;
    end else if (cmd.load_term || cmd.load_err) begin
      out_byte  <= 8'd0;
      out_last  <= 1'b1;
      bad_label <= cmd.load_err;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxLabel))
    else $error("label count beyond max");
  a_ovf_clear: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == '0))
    else $error("count nonzero while overflowed");
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_len, cmd.load_ch, cmd.load_term, cmd.load_err, cmd.accept}))
    else $error("conflicting datapath commands");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("pending item overwritten");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_ch |-> (idx < count))
    else $error("read past open label");
`endif

endmodule

@@ hdl/dns_name_label_encoder_core.sv @@
// A plain label character is taken with no output item.
// A dot or name end that closes a label of n characters gives n+1 items,
// the length byte first, then the characters, one per cycle while out_ready holds.
// New input is taken only in the idle state, not while items are being emitted.
// Reset (rst, synchronous, active high) clears control, label count and error;
// the label store is not cleared.
module dns_name_label_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       name_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_label
);
  import dnle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dnle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .name_end (name_end),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dnle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .bad_label (bad_label)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import dnle_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandomItems = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       term;
    logic       err;
  } enc_result_t;

  typedef struct packed {
    logic [7:0] c;
    logic       fin;
    logic       hold;
  } name_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'd0;
  logic       name_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_label;

  name_item_t  name_q[$];
  enc_result_t encoded_q[$];

  logic [7:0]  label_buf [MaxLabel];
  int unsigned open_len = 0;
  bit          label_ovf = 1'b0;

  int err_count  = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int mode_left  = 0;
  int rdy_mode   = 0;
  logic [7:0] stall_pat = 8'hFF;

  dns_name_label_encoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .name_end (name_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last),
    .bad_label(bad_label)
  );

  always #1 clk = ~clk;

  function automatic enc_result_t mk_result(input logic [7:0] code, input logic term,
                                            input logic err);
    enc_result_t r;
    r.code = code;
    r.term = term;
    r.err  = err;
    return r;
  endfunction

  task automatic close_label();
    if (open_len > 0) begin
      encoded_q.insert(encoded_q.size(), mk_result(open_len[7:0], 1'b0, 1'b0));
      for (int i = 0; i < open_len; i++)
        encoded_q.insert(encoded_q.size(), mk_result(label_buf[i], 1'b0, 1'b0));
      open_len = 0;
    end
  endtask

  task automatic encode_char(input logic [7:0] c, input logic fin);
    if (!label_ovf) begin
      if (c == DotChar) begin
        close_label();
      end else if (open_len < MaxLabel) begin
        label_buf[open_len] = c;
        open_len++;
      end else begin
        label_ovf = 1'b1;
        open_len = 0;
      end
    end
    if (fin) begin
      if (label_ovf) begin
        encoded_q.insert(encoded_q.size(), mk_result(8'd0, 1'b1, 1'b1));
        label_ovf = 1'b0;
        open_len = 0;
      end else begin
        close_label();
        encoded_q.insert(encoded_q.size(), mk_result(8'd0, 1'b1, 1'b0));
      end
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10)
      $display("ERROR: %s", msg);
  endtask

  task automatic add_item(input logic [7:0] c, input logic fin, input logic hold);
    name_item_t it;
    it.c    = c;
    it.fin  = fin;
    it.hold = hold;
    name_q.insert(name_q.size(), it);
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == DotChar);
    return c;
  endfunction

  // long_at: index of a label given long_len characters, -1 for none
  task automatic build_name(input int long_at, input int long_len, input bit noisy,
                            input bit hold);
    logic [7:0] chars[$];
    int nlab;
    int len;
    if (noisy) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        chars.insert(chars.size(), ($urandom_range(0, 3) == 0) ? DotChar : label_char());
    end else begin
      if ($urandom_range(0, 7) == 0) chars.insert(chars.size(), DotChar);
      nlab = $urandom_range(1, 4);
      if (long_at >= 0) nlab = long_at + 1 + int'($urandom_range(0, 1));
      for (int l = 0; l < nlab; l++) begin
        if (l == long_at) len = long_len;
        else len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) chars.insert(chars.size(), label_char());
        if (l < nlab - 1) begin
          chars.insert(chars.size(), DotChar);
          if ($urandom_range(0, 5) == 0) chars.insert(chars.size(), DotChar);
        end
      end
      if ($urandom_range(0, 5) == 0) chars.insert(chars.size(), DotChar);
    end
    for (int i = 0; i < chars.size(); i++)
      add_item(chars[i], i == chars.size() - 1, hold && i == 0);
  endtask

  // sender: bursts with random gaps, optional hold until all output has drained
  always @(posedge clk) begin
    name_item_t it;
    logic nxt_valid;
    if (!rst) begin
      if (in_valid && in_ready)
        encode_char(ch, name_end);
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (name_q.size() > 0 && !(name_q[0].hold && encoded_q.size() != 0)) begin
          it = name_q.pop_front();
          ch        <= it.c;
          name_end  <= it.fin;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // receiver: checks each item and stalls in randomly chosen modes, one a rotating pattern
  always @(posedge clk) begin
    enc_result_t e;
    logic r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (encoded_q.size() == 0) begin
          flag_error($sformatf("unexpected item byte=%0d last=%0b bad=%0b",
                               out_byte, out_last, bad_label));
        end else begin
          e = encoded_q.pop_front();
          if (out_byte !== e.code || out_last !== e.term || bad_label !== e.err)
            flag_error($sformatf("exp byte=%0d last=%0b bad=%0b, got byte=%0d last=%0b bad=%0b",
                                 e.code, e.term, e.err, out_byte, out_last, bad_label));
        end
      end
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 64);
        stall_pat = 8'($urandom_range(1, 255));
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        0: r = 1'b1;
        1: r = 1'($urandom_range(0, 1));
        2: r = ($urandom_range(0, 7) != 0);
        default: begin
          r = stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
      endcase
      out_ready <= r;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int start_size;
    int rand_items;
    // lone dot at end, zero and 0xFF bytes, repeated dot, leading and trailing dots
    add_item(DotChar, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(DotChar, 1'b0, 1'b0);
    add_item(DotChar, 1'b0, 1'b0);
    add_item(8'h41, 1'b1, 1'b0);
    add_item(DotChar, 1'b0, 1'b0);
    add_item(8'h7F, 1'b0, 1'b0);
    add_item(8'h80, 1'b0, 1'b0);
    add_item(DotChar, 1'b1, 1'b0);
    add_item(8'h01, 1'b1, 1'b0);
    add_item(DotChar, 1'b0, 1'b0);
    add_item(DotChar, 1'b0, 1'b0);
    add_item(DotChar, 1'b1, 1'b0);
    add_item(8'hAA, 1'b0, 1'b0);
    add_item(8'h55, 1'b0, 1'b0);
    add_item(DotChar, 1'b0, 1'b0);
    add_item(8'h0F, 1'b0, 1'b0);
    add_item(8'hF0, 1'b1, 1'b0);

    // longest legal label, then a label that overflows
    build_name(0, MaxLabel, 1'b0, 1'b1);
    build_name(1, $urandom_range(MaxLabel + 1, MaxLabel + 4), 1'b0, 1'b0);

    rand_items = 0;
    while (rand_items < RandomItems) begin
      start_size = name_q.size();
      build_name(-1, 0, $urandom_range(0, 4) == 0, $urandom_range(0, 19) == 0);
      rand_items += name_q.size() - start_size;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (name_q.size() != 0 || in_valid || encoded_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (encoded_q.size() != 0)
      flag_error($sformatf("%0d items never arrived", encoded_q.size()));

    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dnle_pkg.sv
hdl/dnle_ctrl.sv
hdl/dnle_dp.sv
hdl/dns_name_label_encoder_core.sv
test/testbench.sv
